[rtl/pclrs_pkg.sv]
`timescale 1ns / 1ps
package pclrs_pkg;

	// default geometry
	localparam int POS_BITS_DEF   = 16;
	localparam int GRID_BITS_DEF  = 5;
	localparam int MAX_POINTS_DEF = 4096;

	localparam int MAX_RESULTS = 64;
	localparam int CNT_W       = 7;

	// request and result field widths
	localparam int FUNC_W = 2;
	localparam int ID_W   = 12;
	localparam int COORD_W = 16;
	localparam int RAD_W  = 16;
	localparam int DSQ_OUT_W = 30;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
	localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [ID_W-1:0]    point_id;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [COORD_W-1:0] pos_z;
		logic [RAD_W-1:0]   radius;
	} req_item_t;

	typedef struct packed {
		logic                 found;
		logic [ID_W-1:0]      match_id;
		logic [DSQ_OUT_W-1:0] dist_sq;
		logic                 truncated;
		logic                 last;
	} rsp_item_t;

endpackage

[rtl/pclrs_stream_if.sv]
`timescale 1ns / 1ps
interface pclrs_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/periodic_cell_list_radius_search_top.sv]
`timescale 1ns / 1ps
// Periodic 3-D cell list with radius search. A clear (func 0) sweeps every
// entry of both memories, one entry a cycle; the same sweep runs after
// reset, and no beat is taken on req until it ends. An insert (func 1)
// does one read of the cell head and the point entry, then one write back.
// A query (func 2) runs a setup step, a cell read and check for every cell
// of the covering cube and a read, multiply and sum for every chain entry
// examined, then a closing step, so its length follows the occupancy of the
// visited cells; the chain walk is serial, since each next id is only known
// once the previous entry has come back from the point memory. A stalled
// rsp makes a match or the closing beat wait for the output register.
// Results leave through an output register; a match is held until the next
// match or the close so that last and truncated can be set on the final
// beat. One item is worked on at a time.
module periodic_cell_list_radius_search_top
	import pclrs_pkg::*;
#(
	parameter int POS_BITS   = POS_BITS_DEF,
	parameter int GRID_BITS  = GRID_BITS_DEF,
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pclrs_stream_if.sink   req,
	pclrs_stream_if.source rsp
);
	localparam int P       = POS_BITS;
	localparam int G       = GRID_BITS;
	localparam int CELL_AW = 3 * G;
	localparam int NCELLS  = 1 << CELL_AW;
	localparam int IDX_W   = $clog2(MAX_POINTS);
	localparam int SHIFT   = P - G;
	localparam int BOX     = 1 << P;
	localparam int SWEEP   = (NCELLS > MAX_POINTS) ? NCELLS : MAX_POINTS;
	localparam int SW_W    = $clog2(SWEEP);
	localparam int CW      = P + 2;
	localparam int LW      = G + 2;
	localparam int NW      = G + 1;
	localparam int DSQ_W   = 2 * P + 2;
	localparam int RW      = (P + 1 > RAD_W) ? P + 1 : RAD_W;
	localparam int CELL_W  = 1 + IDX_W;
	localparam int PT_W    = 2 + IDX_W + 3 * P;

	// controller states
	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_INS   = 4'd2;
	localparam logic [3:0] S_QSET  = 4'd3;
	localparam logic [3:0] S_QCELL = 4'd4;
	localparam logic [3:0] S_QCW   = 4'd5;
	localparam logic [3:0] S_QPT   = 4'd6;
	localparam logic [3:0] S_QMUL  = 4'd7;
	localparam logic [3:0] S_QSUM  = 4'd8;
	localparam logic [3:0] S_QFIN  = 4'd9;

	logic [3:0] state_q;
	logic [SW_W-1:0] sweep_q;

	// item registers
	logic [2:0][P-1:0]   c_q;
	logic [P-1:0]        r_q;
	logic [IDX_W-1:0]    ins_id_q;
	logic [CELL_AW-1:0]  ins_cell_q;
	logic                ins_ign_q;
	logic [2*P-1:0]      r2_q;
	logic [2:0][G-1:0]   lo_q;
	logic [2:0][NW-1:0]  n_q;
	logic [2:0][G-1:0]   idx_q;
	logic [IDX_W-1:0]    cur_id_q;
	logic [CNT_W-1:0]    count_q;
	logic                trunc_q;
	logic                pend_v_q;
	logic [IDX_W-1:0]    pend_id_q;
	logic [DSQ_W-1:0]    pend_dsq_q;
	logic                out_valid_q;
	rsp_item_t           out_q;

	// memory ports
	logic                cell_we, cell_re;
	logic [CELL_AW-1:0]  cell_waddr, cell_raddr;
	logic [CELL_W-1:0]   cell_wdata, cell_rdata;
	logic                pt_we, pt_re;
	logic [IDX_W-1:0]    pt_waddr, pt_raddr;
	logic [PT_W-1:0]     pt_wdata, pt_rdata;

	logic [2:0][2*P-1:0] sq_s2;
	logic [DSQ_W-1:0]    dsq;
	logic                hit;
	logic                out_free;
	logic                out_load;

	// input decode
	logic [2:0][P-1:0]   in_c;
	logic [CELL_AW-1:0]  in_cell;
	logic [RW-1:0]       in_rad;
	logic [P-1:0]        in_r;

	// query setup
	logic [2:0][G-1:0]   lo_nx;
	logic [2:0][NW-1:0]  n_nx;

	// walk advance
	logic [2:0][G-1:0]   idx_nx;
	logic                walk_done;
	logic [CELL_AW-1:0]  q_cell;

	// stored point fields
	logic                pt_stored, pt_more;
	logic [IDX_W-1:0]    pt_next;
	logic [2:0][P-1:0]   pt_pos;

	assign pt_stored = pt_rdata[PT_W-1];
	assign pt_more   = pt_rdata[PT_W-2];
	assign pt_next   = pt_rdata[3*P +: IDX_W];
	assign pt_pos    = pt_rdata[3*P-1:0];

	assign in_c[0] = P'(req.data.pos_x);
	assign in_c[1] = P'(req.data.pos_y);
	assign in_c[2] = P'(req.data.pos_z);
	assign in_cell = {in_c[0][P-1 -: G], in_c[1][P-1 -: G], in_c[2][P-1 -: G]};
	// radius saturates at half the box
	assign in_rad  = RW'(req.data.radius);
	assign in_r    = (in_rad > RW'(BOX / 2)) ? P'(BOX / 2) : P'(in_rad);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
	assign out_free  = !out_valid_q || rsp.ready;

	// a beat enters the output register: a released held match or the final beat
	assign out_load = ((state_q == S_QSUM) && hit && pend_v_q && out_free &&
		count_q != CNT_W'(MAX_RESULTS)) || ((state_q == S_QFIN) && out_free);

	// covering cube: first cell and cell count per axis, capped at the grid
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic [CW-1:0] lo_full, hi_full;
			logic [LW-1:0] lo_c, hi_c, span;
			lo_full = CW'(c_q[a]) + CW'(BOX) - CW'(r_q);
			hi_full = CW'(c_q[a]) + CW'(BOX) + CW'(r_q);
			lo_c = LW'(lo_full >> SHIFT);
			hi_c = LW'(hi_full >> SHIFT);
			span = hi_c - lo_c + LW'(1);
			lo_nx[a] = lo_c[G-1:0];
			n_nx[a] = (span > LW'(1 << G)) ? NW'(1 << G) : NW'(span);
		end
	end

	// z innermost, then y, then x
	always_comb begin
		logic zl, yl, xl;
		zl = (NW'(idx_q[2]) + NW'(1)) == n_q[2];
		yl = (NW'(idx_q[1]) + NW'(1)) == n_q[1];
		xl = (NW'(idx_q[0]) + NW'(1)) == n_q[0];
		idx_nx = idx_q;
		walk_done = 1'b0;
		if (!zl) begin
			idx_nx[2] = idx_q[2] + G'(1);
		end else begin
			idx_nx[2] = '0;
			if (!yl) begin
				idx_nx[1] = idx_q[1] + G'(1);
			end else begin
				idx_nx[1] = '0;
				if (!xl)
					idx_nx[0] = idx_q[0] + G'(1);
				else
					walk_done = 1'b1;
			end
		end
	end

	always_comb begin
		logic [G-1:0] gx, gy, gz;
		gx = lo_q[0] + idx_q[0];
		gy = lo_q[1] + idx_q[1];
		gz = lo_q[2] + idx_q[2];
		q_cell = {gx, gy, gz};
	end

	assign dsq = DSQ_W'(sq_s2[0]) + DSQ_W'(sq_s2[1]) + DSQ_W'(sq_s2[2]);
	assign hit = dsq < DSQ_W'(r2_q);

	// memory port steering
	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = ins_cell_q;
		cell_wdata = {1'b1, ins_id_q};
		cell_re    = 1'b0;
		cell_raddr = q_cell;
		pt_we      = 1'b0;
		pt_waddr   = ins_id_q;
		pt_wdata   = {1'b1, cell_rdata[CELL_W-1], cell_rdata[IDX_W-1:0], c_q};
		pt_re      = 1'b0;
		pt_raddr   = pt_next;
		unique case (state_q)
			S_CLR: begin
				cell_waddr = sweep_q[CELL_AW-1:0];
				cell_wdata = '0;
				cell_we    = 32'(sweep_q) < NCELLS;
				pt_waddr   = sweep_q[IDX_W-1:0];
				pt_wdata   = '0;
				pt_we      = 32'(sweep_q) < MAX_POINTS;
			end
			S_IDLE: begin
				cell_raddr = in_cell;
				pt_raddr   = IDX_W'(req.data.point_id);
				cell_re    = req.valid && req.data.func == FN_INSERT;
				pt_re      = req.valid && req.data.func == FN_INSERT;
			end
			S_INS: begin
				cell_we = !ins_ign_q && !pt_stored;
				pt_we   = !ins_ign_q && !pt_stored;
			end
			S_QCELL: cell_re = 1'b1;
			S_QCW: begin
				pt_raddr = cell_rdata[IDX_W-1:0];
				pt_re    = cell_rdata[CELL_W-1];
			end
			S_QSUM: begin
				// next chain entry once this one is settled
				pt_re = pt_more && !(hit && count_q == CNT_W'(MAX_RESULTS))
					&& !(hit && pend_v_q && !out_free);
			end
			default: ;
		endcase
	end

	pclrs_ram #(.WIDTH(CELL_W), .DEPTH(NCELLS)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.re    (cell_re),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	pclrs_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.re    (pt_re),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	pclrs_dist #(.POS_BITS(P)) u_dist (
		.clk    (clk),
		.pos    (pt_pos),
		.center (c_q),
		.sq_s2  (sq_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			sweep_q     <= '0;
			c_q         <= '0;
			r_q         <= '0;
			ins_id_q    <= '0;
			ins_cell_q  <= '0;
			ins_ign_q   <= 1'b0;
			r2_q        <= '0;
			lo_q        <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			cur_id_q    <= '0;
			count_q     <= '0;
			trunc_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_id_q   <= '0;
			pend_dsq_q  <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					sweep_q <= sweep_q + SW_W'(1);
					if (32'(sweep_q) == SWEEP - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						c_q        <= in_c;
						r_q        <= in_r;
						ins_id_q   <= IDX_W'(req.data.point_id);
						ins_cell_q <= in_cell;
						ins_ign_q  <= 32'(req.data.point_id) >= MAX_POINTS;
						sweep_q    <= '0;
						case (req.data.func)
							FN_CLEAR:  state_q <= S_CLR;
							FN_INSERT: state_q <= S_INS;
							FN_QUERY:  state_q <= S_QSET;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_INS: state_q <= S_IDLE;
				S_QSET: begin
					r2_q     <= r_q * r_q;
					lo_q     <= lo_nx;
					n_q      <= n_nx;
					idx_q    <= '0;
					count_q  <= '0;
					trunc_q  <= 1'b0;
					pend_v_q <= 1'b0;
					state_q  <= S_QCELL;
				end
				S_QCELL: state_q <= S_QCW;
				S_QCW: begin
					if (cell_rdata[CELL_W-1]) begin
						cur_id_q <= cell_rdata[IDX_W-1:0];
						state_q  <= S_QPT;
					end else if (walk_done) begin
						state_q <= S_QFIN;
					end else begin
						idx_q   <= idx_nx;
						state_q <= S_QCELL;
					end
				end
				S_QPT: state_q <= S_QMUL;
				S_QMUL: state_q <= S_QSUM;
				S_QSUM: begin
					if (hit && count_q == CNT_W'(MAX_RESULTS)) begin
						// a match past the limit: the held one closes the query
						trunc_q <= 1'b1;
						count_q <= count_q + CNT_W'(1);
						state_q <= S_QFIN;
					end else if (!(hit && pend_v_q && !out_free)) begin
						if (hit) begin
							if (pend_v_q) begin
								out_q.found     <= 1'b1;
								out_q.match_id  <= ID_W'(pend_id_q);
								out_q.dist_sq   <= DSQ_OUT_W'(pend_dsq_q);
								out_q.truncated <= 1'b0;
								out_q.last      <= 1'b0;
							end
							pend_v_q   <= 1'b1;
							pend_id_q  <= cur_id_q;
							pend_dsq_q <= dsq;
							count_q    <= count_q + CNT_W'(1);
						end
						if (pt_more) begin
							cur_id_q <= pt_next;
							state_q  <= S_QPT;
						end else if (walk_done) begin
							state_q <= S_QFIN;
						end else begin
							idx_q   <= idx_nx;
							state_q <= S_QCELL;
						end
					end
				end
				S_QFIN: begin
					if (out_free) begin
						out_q.found     <= pend_v_q;
						out_q.match_id  <= pend_v_q ? ID_W'(pend_id_q) : '0;
						out_q.dist_sq   <= pend_v_q ? DSQ_OUT_W'(pend_dsq_q) : '0;
						out_q.truncated <= trunc_q;
						out_q.last      <= 1'b1;
						pend_v_q        <= 1'b0;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// never more than one match past the limit is counted
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RESULTS + 1))
		else $error("match count past limit");

	// truncation only once the limit has been passed
	a_trunc_count: assert property (@(posedge clk) disable iff (!arst_n)
		trunc_q |-> count_q == CNT_W'(MAX_RESULTS + 1))
		else $error("truncated without overflow");

	// a query never writes the memories
	a_query_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QCW || state_q == S_QPT || state_q == S_QSUM ||
		 state_q == S_QFIN) |-> !cell_we && !pt_we)
		else $error("memory write during query");

	// no held match once the block is idle again
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_v_q)
		else $error("held match left over");

endmodule

[rtl/pclrs_ram.sv]
`timescale 1ns / 1ps
module pclrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

[rtl/pclrs_dist.sv]
`timescale 1ns / 1ps
module pclrs_dist #(
	parameter int POS_BITS = 16
) (
	input  logic                           clk,
	input  logic [2:0][POS_BITS-1:0]       pos,
	input  logic [2:0][POS_BITS-1:0]       center,
	output logic [2:0][2*POS_BITS-1:0]     sq_s2
);
	localparam int BOX = 1 << POS_BITS;

	logic [2:0][POS_BITS-1:0] gap;
	logic [2:0][POS_BITS-1:0] gap_s1;

	// minimum-image gap per axis
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic [POS_BITS-1:0] d;
			logic [POS_BITS:0]   e;
			d = pos[a] - center[a];
			e = (POS_BITS+1)'(BOX) - {1'b0, d};
			gap[a] = ({1'b0, d} > e) ? POS_BITS'(e) : d;
		end
	end

	always_ff @(posedge clk) begin
		gap_s1 <= gap;
		for (int a = 0; a < 3; a++)
			sq_s2[a] <= gap_s1[a] * gap_s1[a];
	end
endmodule

[test/periodic_cell_list_radius_search_top_test.sv]
`timescale 1ns / 1ps
module periodic_cell_list_radius_search_top_test;
	import pclrs_pkg::*;

	// geometry at the block's defaults
	localparam int GRID_N     = 1 << GRID_BITS_DEF;
	localparam int NCELLS     = 1 << (3 * GRID_BITS_DEF);
	localparam int CELL_SHIFT = POS_BITS_DEF - GRID_BITS_DEF;
	localparam longint BOX    = longint'(1) << POS_BITS_DEF;
	localparam int NPOINTS    = MAX_POINTS_DEF;

	// func code the block leaves unused
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	// a clear sweeps every cell, so the tail wait covers one sweep
	localparam int DRAIN_CYCLES = 34000;
	localparam longint CYCLE_LIMIT = 4000000;

	// expected query hits, built from a private copy of the cell list
	class cell_list_scoreboard;
		bit [ID_W-1:0] head_id [NCELLS];
		bit            head_used [NCELLS];
		bit [ID_W-1:0] next_id [NPOINTS];
		bit            next_more [NPOINTS];
		bit [15:0]     pt_x [NPOINTS];
		bit [15:0]     pt_y [NPOINTS];
		bit [15:0]     pt_z [NPOINTS];
		bit            stored [NPOINTS];
		rsp_item_t     hits_due [$];
		int mismatches;
		int beats_seen;
		int hits_seen;
		int truncations_seen;
		int queries_seen;

		function longint axis_gap(longint p, longint c);
			longint d, e;
			d = (p - c) & (BOX - 1);
			e = BOX - d;
			return (d > e) ? e : d;
		endfunction

		function void run_query(req_item_t it);
			longint c [3];
			longint lo [3];
			longint n [3];
			longint r, r2, hi, dsq, dx, dy, dz, total;
			int cell_idx;
			int id;
			rsp_item_t hit;
			rsp_item_t found_q [$];
			c[0] = it.pos_x;
			c[1] = it.pos_y;
			c[2] = it.pos_z;
			r = it.radius;
			if (r > BOX / 2) r = BOX / 2;
			r2 = r * r;
			total = 0;
			for (int a = 0; a < 3; a++) begin
				lo[a] = (c[a] + BOX - r) >> CELL_SHIFT;
				hi = (c[a] + BOX + r) >> CELL_SHIFT;
				n[a] = hi - lo[a] + 1;
				if (n[a] > GRID_N) n[a] = GRID_N;
			end
			// x outermost, z innermost, each chain newest first
			for (longint ix = 0; ix < n[0]; ix++)
				for (longint iy = 0; iy < n[1]; iy++)
					for (longint iz = 0; iz < n[2]; iz++) begin
						cell_idx = int'((((lo[0] + ix) % GRID_N) << (2 * GRID_BITS_DEF)) |
							(((lo[1] + iy) % GRID_N) << GRID_BITS_DEF) |
							((lo[2] + iz) % GRID_N));
						if (!head_used[cell_idx]) continue;
						id = head_id[cell_idx];
						forever begin
							dx = axis_gap(pt_x[id], c[0]);
							dy = axis_gap(pt_y[id], c[1]);
							dz = axis_gap(pt_z[id], c[2]);
							dsq = dx * dx + dy * dy + dz * dz;
							if (dsq < r2) begin
								if (total < MAX_RESULTS) begin
									hit = '0;
									hit.found = 1'b1;
									hit.match_id = id[ID_W-1:0];
									hit.dist_sq = dsq[DSQ_OUT_W-1:0];
									found_q.push_back(hit);
								end
								total++;
							end
							if (!next_more[id]) break;
							id = next_id[id];
						end
					end
			if (found_q.size() == 0) begin
				hit = '0;
				hit.last = 1'b1;
				found_q.push_back(hit);
			end else begin
				found_q[$].last = 1'b1;
				found_q[$].truncated = (total > MAX_RESULTS);
			end
			foreach (found_q[i]) hits_due.push_back(found_q[i]);
		endfunction

		function void note_request(req_item_t it);
			int cell_idx;
			int id;
			case (it.func)
				FN_CLEAR: begin
					foreach (head_used[i]) head_used[i] = 1'b0;
					foreach (stored[i]) stored[i] = 1'b0;
				end
				FN_INSERT: begin
					id = it.point_id;
					if (!stored[id]) begin
						cell_idx = ((it.pos_x >> CELL_SHIFT) << (2 * GRID_BITS_DEF)) |
							((it.pos_y >> CELL_SHIFT) << GRID_BITS_DEF) |
							(it.pos_z >> CELL_SHIFT);
						pt_x[id] = it.pos_x;
						pt_y[id] = it.pos_y;
						pt_z[id] = it.pos_z;
						next_id[id] = head_id[cell_idx];
						next_more[id] = head_used[cell_idx];
						head_id[cell_idx] = id[ID_W-1:0];
						head_used[cell_idx] = 1'b1;
						stored[id] = 1'b1;
					end
				end
				FN_QUERY: begin
					queries_seen++;
					run_query(it);
				end
				default: ;
			endcase
		endfunction

		function void check_result(rsp_item_t got);
			rsp_item_t want;
			beats_seen++;
			if (hits_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result beat %p", $realtime, got);
				return;
			end
			want = hits_due.pop_front();
			if (got.found) hits_seen++;
			if (got.truncated) truncations_seen++;
			if (got.found !== want.found || got.match_id !== want.match_id ||
				got.dist_sq !== want.dist_sq || got.truncated !== want.truncated ||
				got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result mismatch: expected %p, got %p",
						$realtime, want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pclrs_stream_if #(.T(req_item_t)) req_if ();
	pclrs_stream_if #(.T(rsp_item_t)) rsp_if ();

	periodic_cell_list_radius_search_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source)
	);

	cell_list_scoreboard sb = new();

	int idle_pct;        // chance of a sender gap before a beat
	int stall_pct;       // chance of receiver back-pressure per cycle
	int items_sent;
	longint cycles;
	bit [15:0] hot_x, hot_y, hot_z;   // cluster center so queries find neighbors

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		if (stall_pct == 0)
			rsp_if.ready <= 1'b1;
		else
			rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// accepted beats on either side go to the scoreboard
	always @(posedge clk) begin
		if (arst_n && req_if.valid && req_if.ready) sb.note_request(req_if.data);
		if (arst_n && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", sb.hits_due.size());
			$display("FAILURE");
			$finish;
		end
	end

	// one request beat; an optional gap first, then hold until accepted
	task automatic send_req(input req_item_t it);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= it;
		do @(posedge clk); while (!req_if.ready);
		items_sent++;
	endtask

	task automatic send_fields(input logic [FUNC_W-1:0] fn, input int id,
			input int x, input int y, input int z, input int r);
		req_item_t it;
		it = '0;
		it.func = fn;
		it.point_id = id[ID_W-1:0];
		it.pos_x = x[15:0];
		it.pos_y = y[15:0];
		it.pos_z = z[15:0];
		it.radius = r[15:0];
		send_req(it);
	endtask

	function automatic bit [15:0] near_hot(input bit [15:0] base);
		return base + 16'($urandom_range(0, 3999));
	endfunction

	// mostly clustered inserts and short-radius queries, rare clears and
	// wide queries, a sprinkling of the unused code
	task automatic send_random();
		req_item_t it;
		int pick;
		int rpick;
		pick = $urandom_range(0, 999);
		it = '0;
		it.point_id = ($urandom_range(0, 9) < 7) ? ID_W'($urandom_range(0, 150))
			: ID_W'($urandom);
		it.radius = 16'($urandom);
		if ($urandom_range(0, 4) == 0) begin
			it.pos_x = 16'($urandom);
			it.pos_y = 16'($urandom);
			it.pos_z = 16'($urandom);
		end else begin
			it.pos_x = near_hot(hot_x);
			it.pos_y = near_hot(hot_y);
			it.pos_z = near_hot(hot_z);
		end
		if (pick < 15) begin
			it.func = FN_CLEAR;
			hot_x = 16'($urandom);
			hot_y = 16'($urandom);
			hot_z = 16'($urandom);
		end else if (pick < 570) begin
			it.func = FN_INSERT;
		end else if (pick < 960) begin
			it.func = FN_QUERY;
			rpick = $urandom_range(0, 99);
			if (rpick < 85)
				it.radius = 16'($urandom_range(0, 3000));
			else if (rpick < 98)
				it.radius = 16'($urandom_range(3000, 8000));
			else
				it.radius = 16'($urandom_range(32768, 65535));
		end else begin
			it.func = FN_UNUSED;
		end
		send_req(it);
	endtask

	initial begin
		cycles = 0;
		items_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		hot_x = 16'd1000;
		hot_y = 16'd60000;
		hot_z = 16'd30000;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners, wrap-around, duplicate id, unused code, radius edges
		send_fields(FN_INSERT, 0, 0, 0, 0, 0);
		send_fields(FN_INSERT, 4095, 65535, 65535, 65535, 65535);
		send_fields(FN_INSERT, 1, 32768, 32768, 32768, 0);
		send_fields(FN_INSERT, 0, 500, 500, 500, 0);          // duplicate id ignored
		send_fields(FN_INSERT, 2, 2047, 2048, 2049, 0);
		send_fields(FN_INSERT, 3, 2050, 2047, 2046, 0);
		send_fields(FN_UNUSED, 4095, 65535, 65535, 65535, 65535);
		send_fields(FN_QUERY, 0, 0, 0, 0, 2);                 // hits across the wrap
		send_fields(FN_QUERY, 0, 0, 0, 0, 0);                 // zero radius, no match
		send_fields(FN_QUERY, 0, 16384, 16384, 16384, 100);   // empty neighborhood
		send_fields(FN_QUERY, 0, 2048, 2048, 2048, 10);
		send_fields(FN_QUERY, 0, 65535, 0, 65535, 3000);
		send_fields(FN_QUERY, 0, 32768, 32768, 32768, 32768); // half box, whole grid
		send_fields(FN_QUERY, 0, 12345, 54321, 777, 65535);   // saturated radius
		send_fields(FN_CLEAR, 4095, 65535, 65535, 65535, 65535);
		send_fields(FN_QUERY, 0, 0, 0, 0, 4000);              // nothing left after clear
		send_fields(FN_INSERT, 0, 65535, 0, 65535, 0);
		send_fields(FN_QUERY, 0, 0, 65535, 0, 3);

		// random traffic in four pressure phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 56; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 56; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			repeat (115) send_random();
		end
		req_if.valid <= 1'b0;

		while (sb.hits_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d request beats sent, %0d queries, %0d result beats checked",
			items_sent, sb.queries_seen, sb.beats_seen);
		$display("%0d neighbor hits, %0d truncated queries, %0d mismatches",
			sb.hits_seen, sb.truncations_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.hits_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
